@@ design/brbpm_pkg.sv @@
// Shared types and constants for the ring buffer pointer manager.
`default_nettype none

package brbpm_pkg;

    // Field and register widths
    localparam int REG_W   = 17;
    localparam int MOVE_W  = 8;
    localparam int FUNC_W  = 3;
    // Offsets stay below two ring lengths, the valid mark below three
    localparam int STATE_W = 20;
    localparam int LOC_W   = STATE_W + MOVE_W;

    // Register reset values
    localparam logic [REG_W-1:0] RING_RST = 17'd65536;
    localparam logic [REG_W-1:0] PBLK_RST = 17'd4096;
    localparam logic [REG_W-1:0] CBLK_RST = 17'd4096;

    // Parameter defaults
    localparam int RING_BYTES_MAX_DEF  = 65536;
    localparam int MOVE_BLOCKS_MAX_DEF = 256;

    // Command codes
    typedef enum logic [FUNC_W-1:0] {
        F_PROD  = 3'd0,
        F_CONS  = 3'd1,
        F_MARK  = 3'd2,
        F_MOVE  = 3'd3,
        F_RESET = 3'd4
    } t_func;

    // Register indexes
    typedef enum logic [1:0] {
        REG_RING = 2'd0,
        REG_PBLK = 2'd1,
        REG_CBLK = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

@@ design/block_ring_buffer_pointer_manager.sv @@
// Top level of the ring buffer pointer manager: command pipe, offset state, APB registers.
//
// Usage:
//   Commands arrive on the s_axis stream: the command code in tuser, the valid
//   length and the move count in tdata. Every command gives exactly one result
//   on the m_axis stream: the grant flag in tuser, the block offset and the
//   length available in tdata.
//   The ring and block lengths sit in three APB registers (byte addresses 0, 4
//   and 8). pready is always high; write them only while no command is in flight.
// Timing:
//   A command goes through an input register, then one pass of compare/add
//   logic and a single 8x17 multiply writes the offset state and the result
//   register. One command is taken every cycle unless back pressure stalls the
//   pipe; the rate is set by that single combinational pass.
// Reset:
//   Synchronous, active low. Registers return to ring 65536, blocks 4096;
//   producer and consumer offsets go to zero, the valid mark and consumer start
//   to the "none" marker. No clearing pass is needed.
// Back pressure:
//   When m_axis_tready is low the result holds, the input register keeps one
//   more command, and s_axis_tready drops once both are full.
`default_nettype none

module block_ring_buffer_pointer_manager
    import brbpm_pkg::*;
#(
    parameter int RING_BYTES_MAX  = RING_BYTES_MAX_DEF,
    parameter int MOVE_BLOCKS_MAX = MOVE_BLOCKS_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [16:0] valid_length, [24:17] move_blocks
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] func
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [16:0] block_offset, [33:17] length_available
    output logic [0:0]       m_axis_tuser,   // [0] granted
    // Register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic signed [STATE_W-1:0] NONE_MARK = -1;

    // Registers
    logic [REG_W-1:0] r_ring, r_pblk, r_cblk;

    // Input stage
    logic              r_iv;
    t_func             r_func;
    logic [REG_W-1:0]  r_vlen;
    logic [MOVE_W-1:0] r_mblk;

    // Offset state
    logic signed [STATE_W-1:0] r_ps, r_pe, r_vm, r_cs, r_ce;
    logic signed [STATE_W-1:0] n_ps, n_pe, n_vm, n_cs, n_ce;

    // Result stage
    logic             r_ov;
    logic             r_gnt;
    logic [REG_W-1:0] r_ofs, r_avl;
    logic             n_gnt;
    logic [REG_W-1:0] n_ofs, n_avl;

    logic advance, fire;

    // Effective lengths
    logic [REG_W-1:0] ring_e, pblk_e, cblk_e, ring_z, pblk_z, cblk_z;
    logic signed [STATE_W-1:0] ring_s, plen_s, clen_s, vlen_s;

    // Work signals
    logic signed [STATE_W-1:0] p_ns, p_ne, c_ns, c_ne, c_len, m_ns;
    logic                      c_vin, c_ok, m_refuse;
    logic [MOVE_W+REG_W-1:0]   m_prod;
    logic signed [LOC_W-1:0]   m_loc, m_nsw, ring_w;

    // Handshake
    assign advance       = !r_ov || m_axis_tready;
    assign fire          = r_iv && advance;
    assign s_axis_tready = !r_iv || advance;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_gnt;
    assign m_axis_tdata  = {6'd0, r_avl, r_ofs};
    assign pready        = 1'b1;

    // Register read
    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_RING: prdata = 32'(r_ring);
            REG_PBLK: prdata = 32'(r_pblk);
            REG_CBLK: prdata = 32'(r_cblk);
            default:  prdata = 32'd0;
        endcase
    end

    // Clamp register values into range
    always_comb begin
        ring_z = (r_ring == '0) ? REG_W'(1) : r_ring;
        ring_e = (32'(ring_z) > 32'(RING_BYTES_MAX)) ? REG_W'(RING_BYTES_MAX) : ring_z;
        pblk_z = (r_pblk == '0) ? REG_W'(1) : r_pblk;
        pblk_e = (pblk_z > ring_e) ? ring_e : pblk_z;
        cblk_z = (r_cblk == '0) ? REG_W'(1) : r_cblk;
        cblk_e = (cblk_z > ring_e) ? ring_e : cblk_z;
    end

    assign ring_s = $signed({{(STATE_W-REG_W){1'b0}}, ring_e});
    assign plen_s = $signed({{(STATE_W-REG_W){1'b0}}, pblk_e});
    assign clen_s = $signed({{(STATE_W-REG_W){1'b0}}, cblk_e});
    assign vlen_s = $signed({{(STATE_W-REG_W){1'b0}}, r_vlen});
    assign ring_w = $signed({{(LOC_W-REG_W){1'b0}}, ring_e});

    // Producer request: next block, wrapping at the ring end
    assign p_ns = (r_pe >= ring_s) ? '0 : r_pe;
    assign p_ne = p_ns + plen_s;

    // Consumer request: next block, trimmed at the valid mark
    assign c_ns  = (r_ce >= ring_s) ? '0 : r_ce;
    assign c_ne  = c_ns + clen_s;
    assign c_vin = (c_ns < r_vm) && (r_vm <= c_ne);
    always_comb begin
        c_ok  = 1'b1;
        c_len = clen_s;
        if ((c_ns <= r_ps) && (r_ps <= c_ne)) begin
            if (c_vin) begin
                c_len = r_vm - c_ns;
            end else begin
                c_ok  = 1'b0;
                c_len = '0;
            end
        end else if (c_vin) begin
            c_len = r_vm - c_ns;
        end
    end

    // Move: relocate by whole producer blocks, one wrap at most
    assign m_prod = (MOVE_W+REG_W)'(r_mblk) * (MOVE_W+REG_W)'(pblk_e);
    assign m_loc  = LOC_W'(r_ps) + $signed({{(LOC_W-MOVE_W-REG_W){1'b0}}, m_prod});
    assign m_nsw  = (m_loc >= ring_w) ? (m_loc - ring_w) : m_loc;
    assign m_ns   = m_nsw[STATE_W-1:0];
    always_comb begin
        if (m_nsw >= ring_w) begin
            m_refuse = 1'b1;
        end else if (r_ps < r_cs) begin
            m_refuse = (m_ns < r_ps) || (m_ns >= r_cs);
        end else begin
            m_refuse = (r_cs <= m_ns) && (m_ns < r_ps);
        end
    end

    // Next state and result per command
    always_comb begin
        n_ps  = r_ps;
        n_pe  = r_pe;
        n_vm  = r_vm;
        n_cs  = r_cs;
        n_ce  = r_ce;
        n_gnt = 1'b0;
        n_ofs = '0;
        n_avl = '0;
        case (r_func)
            F_PROD: begin
                if (!((p_ns <= r_cs) && (r_cs < p_ne))) begin
                    if (r_cs == NONE_MARK) n_cs = '0;
                    n_ps  = p_ns;
                    n_pe  = p_ne;
                    n_gnt = 1'b1;
                    n_ofs = p_ns[REG_W-1:0];
                end
            end
            F_CONS: begin
                if ((r_ce != r_vm) && c_ok) begin
                    n_cs  = c_ns;
                    n_ce  = c_ns + c_len;
                    n_gnt = 1'b1;
                    n_ofs = c_ns[REG_W-1:0];
                    n_avl = c_len[REG_W-1:0];
                end
            end
            F_MARK: begin
                if (r_vlen == '0) begin
                    n_vm  = r_ps;
                    n_pe  = r_ps;
                    n_ofs = r_ps[REG_W-1:0];
                end else begin
                    n_vm  = r_ps + vlen_s;
                    n_ps  = r_pe;
                    n_ofs = r_pe[REG_W-1:0];
                end
                n_gnt = 1'b1;
            end
            F_MOVE: begin
                if ((32'(r_mblk) < 32'(MOVE_BLOCKS_MAX)) && !m_refuse) begin
                    n_ps  = m_ns;
                    n_pe  = m_ns + plen_s;
                    n_gnt = 1'b1;
                    n_ofs = m_ns[REG_W-1:0];
                end
            end
            F_RESET: begin
                n_ps  = '0;
                n_pe  = '0;
                n_vm  = NONE_MARK;
                n_cs  = NONE_MARK;
                n_ce  = '0;
                n_gnt = 1'b1;
            end
            default: begin
                n_gnt = 1'b0;
            end
        endcase
    end

    // Control state, offsets and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv   <= 1'b0;
            r_ov   <= 1'b0;
            r_ps   <= '0;
            r_pe   <= '0;
            r_vm   <= NONE_MARK;
            r_cs   <= NONE_MARK;
            r_ce   <= '0;
            r_ring <= RING_RST;
            r_pblk <= PBLK_RST;
            r_cblk <= CBLK_RST;
        end else begin
            if (s_axis_tready) r_iv <= s_axis_tvalid;
            if (advance)       r_ov <= r_iv;
            if (fire) begin
                r_ps <= n_ps;
                r_pe <= n_pe;
                r_vm <= n_vm;
                r_cs <= n_cs;
                r_ce <= n_ce;
            end
            if (psel && penable && pwrite) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_RING: r_ring <= pwdata[REG_W-1:0];
                    REG_PBLK: r_pblk <= pwdata[REG_W-1:0];
                    REG_CBLK: r_cblk <= pwdata[REG_W-1:0];
                    default:  r_ring <= r_ring;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_func <= t_func'(s_axis_tuser[FUNC_W-1:0]);
            r_vlen <= s_axis_tdata[REG_W-1:0];
            r_mblk <= s_axis_tdata[REG_W+MOVE_W-1:REG_W];
        end
        if (fire) begin
            r_gnt <= n_gnt;
            r_ofs <= n_ofs;
            r_avl <= n_avl;
        end
    end

    // Reset command always grants at offset zero with no length
    a_reset_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_func == F_RESET) |=> (r_ov && r_gnt && r_ofs == '0 && r_avl == '0))
        else $error("reset command result wrong");

    // Only a consumer request reports a length
    a_len_only_cons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_func != F_CONS) |=> (r_avl == '0))
        else $error("length reported for non-consumer command");

    // Producer offsets and the consumer end never go negative
    a_prod_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ps[STATE_W-1] && !r_pe[STATE_W-1] && !r_ce[STATE_W-1])
        else $error("offset went negative");

    // Consumer start and valid mark never fall below the none marker
    a_marker_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cs >= NONE_MARK) && (r_vm >= NONE_MARK))
        else $error("marker below none");

    // Input stalls only when both stages are full and the sink stalls
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_iv && r_ov && !m_axis_tready))
        else $error("input stalled without cause");

endmodule

`default_nettype wire
